/* hw/rtl/mmrp_pkg.sv */
// Shared types, constants and field tables of the meter response parser.
`default_nettype none
package mmrp_pkg;

  localparam int NUM_POINTS = 12;
  localparam int POINT_W    = 4;
  localparam int READING_W  = 33;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NO_MATCH  = 3'd1;
  localparam status_t ST_TRUNCATED = 3'd2;
  localparam status_t ST_PROTOCOL  = 3'd3;
  localparam status_t ST_LENGTH    = 3'd4;
  localparam status_t ST_UNIT      = 3'd5;
  localparam status_t ST_FUNCTION  = 3'd6;
  localparam status_t ST_BYTE_CNT  = 3'd7;

  // Configuration register indexes.
  typedef logic [0:0] cfg_addr_t;
  localparam cfg_addr_t CFG_EXP_TRANSACTION = 1'd0;
  localparam cfg_addr_t CFG_EXP_UNIT        = 1'd1;

  localparam logic [15:0] EXP_TRANSACTION_RST = 16'hDEAD;
  localparam logic [7:0]  EXP_UNIT_RST        = 8'h01;
  localparam logic [15:0] PROTOCOL_ID         = 16'h0000;
  localparam logic [15:0] RESP_LEN            = 16'd183;
  localparam logic [7:0]  FUNC_CODE           = 8'h03;
  localparam logic [7:0]  BYTE_CNT            = 8'd180;
  localparam logic [2:0]  HDR_LAST            = 3'd5;

  typedef enum logic [3:0] {
    PH_SEEK  = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_MATCH = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_U32 = 2'd0,
    KIND_S16 = 2'd1,
    KIND_S32 = 2'd2
  } kind_t;

  // One datagram verdict handed from the parser to the result stage.
  typedef struct packed {
    logic    valid;
    status_t status;
  } pkt_t;

  // Register-data offset one past the last byte of each value.
  function automatic logic [7:0] fld_end(input logic [POINT_W-1:0] k);
    logic [7:0] e;
    unique case (k)
      4'd0:    e = 8'd8;
      4'd1:    e = 8'd12;
      4'd2:    e = 8'd30;
      4'd3:    e = 8'd32;
      4'd4:    e = 8'd46;
      4'd5:    e = 8'd48;
      4'd6:    e = 8'd62;
      4'd7:    e = 8'd64;
      4'd8:    e = 8'd160;
      4'd9:    e = 8'd164;
      4'd10:   e = 8'd172;
      4'd11:   e = 8'd180;
      default: e = 8'd0;
    endcase
    return e;
  endfunction

  function automatic kind_t fld_kind(input logic [POINT_W-1:0] k);
    kind_t r;
    if (k < 4'd2) begin
      r = KIND_U32;
    end else if (k < 4'd8) begin
      r = KIND_S16;
    end else begin
      r = KIND_S32;
    end
    return r;
  endfunction

  function automatic logic [READING_W-1:0] reading_of(input logic [POINT_W-1:0] k,
                                                      input logic [31:0] v);
    logic [READING_W-1:0] r;
    unique case (fld_kind(k))
      KIND_U32: r = {1'b0, v};
      KIND_S16: r = {{17{v[15]}}, v[15:0]};
      KIND_S32: r = {v[31], v};
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/modbus_meter_response_parser.sv */
// Top level of the meter response parser: input buffer, byte parser, result stage.
// Takes one datagram byte per cycle while the parser is not stalled; a byte is parsed
// from the skid buffer's main register. The first result is registered once the parser
// takes the final byte; a good response sends twelve results, one on each ready cycle.
// A final byte, or a byte that stores a value, waits while the previous datagram's
// results are still going out. Synchronous active-high reset restores both ID registers.
`default_nettype none
module modbus_meter_response_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_packet
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [32:0] reading
  output logic [6:0]       m_tuser,   // [2:0] status, [6:3] point
  output logic             m_tlast    // final_res
);

  logic                               byte_valid;
  logic [8:0]                         byte_data;
  logic                               byte_take;
  logic                               emit_free;
  mmrp_pkg::pkt_t                     pkt;
  logic [mmrp_pkg::POINT_W-1:0]       rd_point;
  logic [31:0]                        rd_value;
  mmrp_pkg::status_t                  out_status;
  logic [mmrp_pkg::POINT_W-1:0]       out_point;
  logic [mmrp_pkg::READING_W-1:0]     out_reading;

  mmrp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   ({s_tlast, s_tdata}),
    .out_valid (byte_valid),
    .out_data  (byte_data),
    .out_take  (byte_take)
  );

  mmrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (byte_valid),
    .in_byte   (byte_data[7:0]),
    .in_eop    (byte_data[8]),
    .in_take   (byte_take),
    .emit_free (emit_free),
    .pkt       (pkt),
    .rd_point  (rd_point),
    .rd_value  (rd_value)
  );

  mmrp_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .emit_free   (emit_free),
    .rd_point    (rd_point),
    .rd_value    (rd_value),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_point   (out_point),
    .out_reading (out_reading),
    .out_final   (m_tlast)
  );

  assign m_tdata = {7'd0, out_reading};
  assign m_tuser = {out_point, out_status};

  // Only a good response spans several results.
  a_multi_only_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (out_status == mmrp_pkg::ST_OK))
    else $error("non-final result carries an error status");

  // An error result is a single final result with point and reading cleared.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != mmrp_pkg::ST_OK) |->
    (m_tlast && out_point == '0 && out_reading == '0))
    else $error("malformed error result");

  // A good response ends on the last meter point.
  a_ok_ends_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && out_status == mmrp_pkg::ST_OK) |->
    (out_point == mmrp_pkg::POINT_W'(mmrp_pkg::NUM_POINTS - 1)))
    else $error("good response ended early");

  // Points of one response advance by one on each transfer.
  a_point_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
    (m_tvalid && out_point == $past(out_point) + 4'd1))
    else $error("point sequence broken");

endmodule
`default_nettype wire

/* hw/rtl/mmrp_skid.sv */
// Two-entry input skid buffer that keeps tready off the downstream path.
`default_nettype none
module mmrp_skid (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [8:0] in_data,
  output logic            out_valid,
  output logic [8:0]      out_data,
  input  wire logic       out_take
);

  logic       main_valid;
  logic [8:0] main_data;
  logic       skid_valid;
  logic [8:0] skid_data;
  logic       in_fire;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_take) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_take) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mmrp_parser.sv */
// Per-byte MBAP header walk, response checks and meter value capture.
`default_nettype none
module mmrp_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire mmrp_pkg::cfg_addr_t           cfg_addr,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          in_valid,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_eop,
  output logic                               in_take,
  input  wire logic                          emit_free,
  output mmrp_pkg::pkt_t                     pkt,
  input  wire logic [mmrp_pkg::POINT_W-1:0]  rd_point,
  output logic [31:0]                        rd_value
);

  logic [15:0]           exp_transaction;
  logic [7:0]            exp_unit;
  mmrp_pkg::phase_t      phase, phase_next;
  logic [15:0]           offset, offset_next;
  logic [39:0]           hdr, hdr_next;
  mmrp_pkg::status_t     first_error, first_error_next;
  logic [31:0]           field_shift, field_shift_next;
  logic [31:0]           value_store [mmrp_pkg::NUM_POINTS];

  logic [47:0]           hdr_full;
  logic [15:0]           len;
  logic [16:0]           offset_inc;
  logic [15:0]           body_pos;
  logic                  cap_en;
  logic [mmrp_pkg::NUM_POINTS-1:0] cap_hit;
  mmrp_pkg::status_t     eop_status;

  assign len        = hdr[15:0];
  assign hdr_full   = {hdr, in_byte};
  assign offset_inc = {1'b0, offset} + 17'd1;
  assign body_pos   = offset - 16'd3;

  // Value capture in the matching body; only the final byte of a field writes.
  assign cap_en = (phase == mmrp_pkg::PH_MATCH) && (first_error == mmrp_pkg::ST_OK) &&
                  (offset >= 16'd3) && (body_pos < {8'd0, mmrp_pkg::BYTE_CNT});

  always_comb begin
    for (int k = 0; k < mmrp_pkg::NUM_POINTS; k++) begin
      cap_hit[k] = cap_en &&
                   (body_pos[7:0] + 8'd1 == mmrp_pkg::fld_end(mmrp_pkg::POINT_W'(k)));
    end
  end

  // A byte that ends a datagram, or that overwrites a value, waits until the
  // result stage has finished with the previous datagram.
  assign in_take = in_valid && (emit_free || (!in_eop && (cap_hit == '0)));

  always_comb begin
    phase_next       = phase;
    offset_next      = offset;
    hdr_next         = hdr;
    first_error_next = first_error;
    field_shift_next = field_shift;
    unique case (phase)
      mmrp_pkg::PH_SEEK: begin
        hdr_next    = hdr_full[39:0];
        offset_next = offset_inc[15:0];
        if (offset[2:0] == mmrp_pkg::HDR_LAST) begin
          offset_next = '0;
          if (hdr_full[47:32] == exp_transaction) begin
            if (hdr_full[31:16] != mmrp_pkg::PROTOCOL_ID) begin
              first_error_next = mmrp_pkg::ST_PROTOCOL;
            end else if (hdr_full[15:0] != mmrp_pkg::RESP_LEN) begin
              first_error_next = mmrp_pkg::ST_LENGTH;
            end
            phase_next = (hdr_full[15:0] == '0) ? mmrp_pkg::PH_DONE : mmrp_pkg::PH_MATCH;
          end else begin
            phase_next = (hdr_full[15:0] == '0) ? mmrp_pkg::PH_SEEK : mmrp_pkg::PH_SKIP;
          end
        end
      end
      mmrp_pkg::PH_SKIP: begin
        offset_next = offset_inc[15:0];
        if (offset_inc >= {1'b0, len}) begin
          offset_next = '0;
          phase_next  = mmrp_pkg::PH_SEEK;
        end
      end
      mmrp_pkg::PH_MATCH: begin
        if (first_error == mmrp_pkg::ST_OK) begin
          priority if (offset == 16'd0) begin
            if (in_byte != exp_unit) first_error_next = mmrp_pkg::ST_UNIT;
          end else if (offset == 16'd1) begin
            if (in_byte != mmrp_pkg::FUNC_CODE) first_error_next = mmrp_pkg::ST_FUNCTION;
          end else if (offset == 16'd2) begin
            if (in_byte != mmrp_pkg::BYTE_CNT) first_error_next = mmrp_pkg::ST_BYTE_CNT;
          end else if (cap_en) begin
            field_shift_next = {field_shift[23:0], in_byte};
          end
        end
        offset_next = offset_inc[15:0];
        if (offset_inc >= {1'b0, len}) phase_next = mmrp_pkg::PH_DONE;
      end
      mmrp_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    unique case (phase_next)
      mmrp_pkg::PH_SKIP, mmrp_pkg::PH_MATCH: eop_status = mmrp_pkg::ST_TRUNCATED;
      mmrp_pkg::PH_DONE:                     eop_status = first_error_next;
      default:                               eop_status = mmrp_pkg::ST_NO_MATCH;
    endcase
  end

  assign pkt.valid  = in_take && in_eop;
  assign pkt.status = eop_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_transaction <= mmrp_pkg::EXP_TRANSACTION_RST;
      exp_unit        <= mmrp_pkg::EXP_UNIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mmrp_pkg::CFG_EXP_TRANSACTION: exp_transaction <= cfg_data;
        mmrp_pkg::CFG_EXP_UNIT:        exp_unit        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mmrp_pkg::PH_SEEK;
      offset      <= '0;
      hdr         <= '0;
      first_error <= mmrp_pkg::ST_OK;
      field_shift <= '0;
    end else if (in_take) begin
      if (in_eop) begin
        phase       <= mmrp_pkg::PH_SEEK;
        offset      <= '0;
        hdr         <= '0;
        first_error <= mmrp_pkg::ST_OK;
        field_shift <= '0;
      end else begin
        phase       <= phase_next;
        offset      <= offset_next;
        hdr         <= hdr_next;
        first_error <= first_error_next;
        field_shift <= field_shift_next;
      end
    end
  end

  // Size-two fields keep all 32 shifted bits; the reader uses the low half.
  always_ff @(posedge clk) begin
    for (int k = 0; k < mmrp_pkg::NUM_POINTS; k++) begin
      if (in_take && cap_hit[k]) value_store[k] <= field_shift_next;
    end
  end

  assign rd_value = (rd_point < mmrp_pkg::POINT_W'(mmrp_pkg::NUM_POINTS)) ?
                    value_store[rd_point] : '0;

endmodule
`default_nettype wire

/* hw/rtl/mmrp_emit.sv */
// Result register that sends one error result or the twelve meter values.
`default_nettype none
module mmrp_emit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mmrp_pkg::pkt_t                  pkt,
  output logic                                 emit_free,
  output logic [mmrp_pkg::POINT_W-1:0]         rd_point,
  input  wire logic [31:0]                     rd_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mmrp_pkg::status_t                    out_status,
  output logic [mmrp_pkg::POINT_W-1:0]         out_point,
  output logic [mmrp_pkg::READING_W-1:0]       out_reading,
  output logic                                 out_final
);

  logic                         out_fire;
  logic [mmrp_pkg::POINT_W-1:0] point_inc;

  assign out_fire  = out_valid && out_ready;
  assign emit_free = !out_valid || (out_fire && out_final);
  assign point_inc = out_point + 4'd1;
  assign rd_point  = pkt.valid ? '0 : point_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pkt.valid) begin
      out_valid <= 1'b1;
    end else if (out_fire && out_final) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid) begin
      out_status  <= pkt.status;
      out_point   <= '0;
      out_final   <= (pkt.status != mmrp_pkg::ST_OK);
      out_reading <= (pkt.status == mmrp_pkg::ST_OK) ?
                     mmrp_pkg::reading_of('0, rd_value) : '0;
    end else if (out_fire && !out_final) begin
      out_point   <= point_inc;
      out_final   <= (point_inc == mmrp_pkg::POINT_W'(mmrp_pkg::NUM_POINTS - 1));
      out_reading <= mmrp_pkg::reading_of(point_inc, rd_value);
    end
  end

endmodule
`default_nettype wire
